// ===== rtl/bfr_pkg.sv =====
`timescale 1ns / 1ps
// Package for the byte frame receiver: sizes, codes, phase type and the
// command and status structs shared by the controller and the datapath.
package bfr_pkg;

  localparam int MAX_PAYLOAD = 32;
  localparam int IDX_W       = $clog2(MAX_PAYLOAD);
  localparam int LEN_W       = $clog2(MAX_PAYLOAD + 1);
  localparam int BYTE_W      = 8;
  localparam int TICK_W      = 16;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 16;

  localparam logic [BYTE_W-1:0] START_BYTE_RST = 8'hAA;
  localparam logic [TICK_W-1:0] TIMEOUT_RST    = 16'd100;
  localparam logic [TICK_W-1:0] IDLE_MAX       = {TICK_W{1'b1}};

  localparam logic KIND_BYTE = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_START_BYTE = 1'b0,
    REG_TIMEOUT    = 1'b1
  } cfg_reg_t;

  typedef enum logic [2:0] {
    PH_SOF   = 3'd0,
    PH_ID    = 3'd1,
    PH_LEN   = 3'd2,
    PH_DATA  = 3'd3,
    PH_CHK   = 3'd4,
    PH_DRAIN = 3'd5
  } phase_t;

  typedef struct packed {
    logic tick_acc;
    logic byte_acc;
    logic restart;
    logic load_id;
    logic load_len;
    logic store_byte;
    logic drain_start;
    logic emit;
  } bfr_cmd_t;

  typedef struct packed {
    logic idle_over;
    logic sof_match;
    logic len_over;
    logic len_zero;
    logic fill_done;
    logic sum_ok;
    logic drain_last;
    logic out_free;
  } bfr_status_t;

endpackage

// ===== rtl/bfr_ctrl.sv =====
`timescale 1ns / 1ps
// Frame parser controller: phase state machine that issues datapath commands.
// Depends on bfr_pkg.
module bfr_ctrl
  import bfr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_kind,
  output logic        in_stall,
  input  bfr_status_t sts,
  output bfr_cmd_t    cmd
);

  phase_t state_r, state_nxt;
  phase_t eff_phase;
  logic   acc;
  logic   timed_out;

  assign in_stall  = (state_r == PH_DRAIN);
  assign acc       = in_valid && !in_stall;
  assign timed_out = (state_r != PH_SOF) && sts.idle_over;
  assign eff_phase = timed_out ? PH_SOF : state_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= PH_SOF;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    if (state_r == PH_DRAIN) begin
      if (sts.out_free && sts.drain_last) begin
        state_nxt = PH_SOF;
      end
    end else if (acc && in_kind == KIND_TICK) begin
      state_nxt = eff_phase;
    end else if (acc) begin
      unique case (eff_phase)
        PH_ID:   state_nxt = PH_LEN;
        PH_LEN: begin
          if (sts.len_over) begin
            state_nxt = PH_SOF;
          end else begin
            state_nxt = sts.len_zero ? PH_CHK : PH_DATA;
          end
        end
        PH_DATA: state_nxt = sts.fill_done ? PH_CHK : PH_DATA;
        PH_CHK:  state_nxt = sts.sum_ok ? PH_DRAIN : PH_SOF;
        default: state_nxt = sts.sof_match ? PH_ID : PH_SOF;
      endcase
    end
  end

  always_comb begin
    cmd          = '0;
    cmd.tick_acc = acc && (in_kind == KIND_TICK);
    cmd.byte_acc = acc && (in_kind == KIND_BYTE);
    cmd.restart  = acc && timed_out;
    if (state_r == PH_DRAIN) begin
      cmd.emit = sts.out_free;
    end else if (cmd.byte_acc) begin
      unique case (eff_phase)
        PH_ID:   cmd.load_id = 1'b1;
        PH_LEN: begin
          cmd.restart  = sts.len_over;
          cmd.load_len = !sts.len_over;
        end
        PH_DATA: cmd.store_byte = 1'b1;
        PH_CHK:  cmd.drain_start = 1'b1;
        default: cmd.load_id = 1'b0;
      endcase
    end
  end

endmodule

// ===== rtl/bfr_datapath.sv =====
`timescale 1ns / 1ps
// Frame parser datapath: configuration, idle counter, checksum, payload memory
// and the output register. Depends on bfr_pkg.
module bfr_datapath
  import bfr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_kind,
  input  logic [BYTE_W-1:0]     in_rx_byte,
  input  bfr_cmd_t              cmd,
  output bfr_status_t           sts,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [BYTE_W-1:0]     out_frame_id,
  output logic [LEN_W-1:0]      out_payload_len,
  output logic [BYTE_W-1:0]     out_payload_byte,
  output logic [IDX_W-1:0]      out_byte_index,
  output logic                  out_last
);

  logic [BYTE_W-1:0] start_byte_r;
  logic [TICK_W-1:0] timeout_r;
  logic [TICK_W-1:0] idle_r, idle_inc;
  logic [BYTE_W-1:0] id_r;
  logic [LEN_W-1:0]  len_r;
  logic [LEN_W-1:0]  fill_r;
  logic [LEN_W:0]    fill_inc;
  logic [BYTE_W-1:0] sum_r;
  logic [BYTE_W-1:0] mem [MAX_PAYLOAD];
  logic              out_valid_r;
  logic [BYTE_W-1:0] out_id_r, out_byte_r;
  logic [LEN_W-1:0]  out_len_r;
  logic [IDX_W-1:0]  out_idx_r;
  logic              out_last_r;

  assign idle_inc = (idle_r == IDLE_MAX) ? idle_r : idle_r + 1'b1;
  assign fill_inc = {1'b0, fill_r} + 1'b1;

  assign sts.idle_over  = ((in_kind == KIND_TICK) ? idle_inc : idle_r) > timeout_r;
  assign sts.sof_match  = (in_rx_byte == start_byte_r);
  assign sts.len_over   = (in_rx_byte > BYTE_W'(MAX_PAYLOAD));
  assign sts.len_zero   = (in_rx_byte == '0);
  assign sts.fill_done  = (fill_inc >= {1'b0, len_r});
  assign sts.sum_ok     = (in_rx_byte == sum_r);
  assign sts.drain_last = (len_r == '0) || (fill_inc == {1'b0, len_r});
  assign sts.out_free   = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_byte_r <= START_BYTE_RST;
      timeout_r    <= TIMEOUT_RST;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_idx))
        REG_START_BYTE: start_byte_r <= cfg_wdata[BYTE_W-1:0];
        REG_TIMEOUT:    timeout_r    <= cfg_wdata[TICK_W-1:0];
        default:        start_byte_r <= start_byte_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idle_r <= '0;
      id_r   <= '0;
      len_r  <= '0;
      fill_r <= '0;
      sum_r  <= '0;
    end else begin
      if (cmd.tick_acc) begin
        idle_r <= idle_inc;
      end else if (cmd.byte_acc) begin
        idle_r <= '0;
      end
      if (cmd.restart) begin
        fill_r <= '0;
        len_r  <= '0;
      end
      if (cmd.load_id) begin
        id_r  <= in_rx_byte;
        sum_r <= in_rx_byte;
      end
      if (cmd.load_len) begin
        len_r  <= in_rx_byte[LEN_W-1:0];
        sum_r  <= sum_r + in_rx_byte;
        fill_r <= '0;
      end
      if (cmd.store_byte) begin
        sum_r  <= sum_r + in_rx_byte;
        fill_r <= fill_inc[LEN_W-1:0];
      end
      if (cmd.drain_start) begin
        fill_r <= '0;
      end
      if (cmd.emit) begin
        fill_r <= fill_inc[LEN_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.store_byte) begin
      mem[fill_r[IDX_W-1:0]] <= in_rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_id_r   <= id_r;
      out_len_r  <= len_r;
      out_idx_r  <= fill_r[IDX_W-1:0];
      out_last_r <= sts.drain_last;
      out_byte_r <= (len_r == '0) ? '0 : mem[fill_r[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_frame_id     = out_id_r;
  assign out_payload_len  = out_len_r;
  assign out_payload_byte = out_byte_r;
  assign out_byte_index   = out_idx_r;
  assign out_last         = out_last_r;

endmodule

// ===== rtl/byte_frame_receiver_additive_checksum_unit.sv =====
`timescale 1ns / 1ps
// Top level of the byte frame receiver with additive checksum.
// Depends on bfr_pkg, bfr_ctrl and bfr_datapath.
//
//   Port group  Direction  Contents
//   in_*        input      kind, rx_byte; valid/stall handshake
//   out_*       output     frame_id, payload_len, payload_byte, byte_index, last
//   cfg_*       input      write enable, register index, 16-bit write data
//
// Each received byte or tick item is taken when in_valid is high and in_stall is low.
// A frame whose checksum matches holds in_stall high while the payload memory
// is read out, one payload byte per result (one zero byte for an empty frame),
// and for as long as out_stall holds a result back.
// The output register lets the next item in while the last result waits.
// Reset is synchronous and active low; the payload memory is not cleared.
module byte_frame_receiver_additive_checksum_unit
  import bfr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_kind,
  input  logic [BYTE_W-1:0]     in_rx_byte,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [BYTE_W-1:0]     out_frame_id,
  output logic [LEN_W-1:0]      out_payload_len,
  output logic [BYTE_W-1:0]     out_payload_byte,
  output logic [IDX_W-1:0]      out_byte_index,
  output logic                  out_last
);

  bfr_cmd_t    cmd;
  bfr_status_t sts;

  bfr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_kind  (in_kind),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  bfr_datapath u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_idx          (cfg_idx),
    .cfg_wdata        (cfg_wdata),
    .in_kind          (in_kind),
    .in_rx_byte       (in_rx_byte),
    .cmd              (cmd),
    .sts              (sts),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_frame_id     (out_frame_id),
    .out_payload_len  (out_payload_len),
    .out_payload_byte (out_payload_byte),
    .out_byte_index   (out_byte_index),
    .out_last         (out_last)
  );

endmodule

// ===== rtl/bfr_checker.sv =====
`timescale 1ns / 1ps
// Port-level checker for the byte frame receiver, bound to the top level.
// Depends on bfr_pkg.
module bfr_checker
  import bfr_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_stall,
  input logic [BYTE_W-1:0] out_frame_id,
  input logic [LEN_W-1:0]  out_payload_len,
  input logic [BYTE_W-1:0] out_payload_byte,
  input logic [IDX_W-1:0]  out_byte_index,
  input logic              out_last
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_payload_byte)
      && $stable(out_byte_index) && $stable(out_last))
    else $error("Result changed while stalled.");

  a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_payload_len <= LEN_W'(MAX_PAYLOAD))
    else $error("Payload length above limit.");

  a_empty_frame: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_payload_len == '0 |->
      out_last && out_byte_index == '0 && out_payload_byte == '0)
    else $error("Empty frame result malformed.");

  a_last_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_payload_len != '0 |->
      out_last == ((LEN_W'(out_byte_index) + 1'b1) == out_payload_len))
    else $error("Last flag does not match byte position.");

  a_index_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_last ##1 out_valid |->
      out_byte_index == $past(out_byte_index) + 1'b1
      && out_frame_id == $past(out_frame_id))
    else $error("Byte index did not advance within a frame.");

endmodule

bind byte_frame_receiver_additive_checksum_unit bfr_checker u_bfr_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_frame_id     (out_frame_id),
  .out_payload_len  (out_payload_len),
  .out_payload_byte (out_payload_byte),
  .out_byte_index   (out_byte_index),
  .out_last         (out_last)
);
